FILE: hw/rtl/sentence_header_checksum_check_unit_macros.svh
// assertion macros used by the checker top level
`ifndef SENTENCE_HEADER_CHECKSUM_CHECK_UNIT_MACROS_SVH
`define SENTENCE_HEADER_CHECKSUM_CHECK_UNIT_MACROS_SVH

`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define SHCHK_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("shchk assertion failed");
// consequent must hold in the cycle after the antecedent
`define SHCHK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("shchk assertion failed");
`else
`define SHCHK_ASSERT(label, clk, rstn, prop)
`define SHCHK_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/shchk_pkg.sv
`default_nettype none

package shchk_pkg;

  localparam int unsigned LenW = 6;

  localparam int unsigned DefMaxCommandLen   = 15;
  localparam int unsigned DefMaxParameterLen = 31;
  localparam int unsigned DefMaxValueLen     = 63;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  localparam logic [LenW-1:0] PrefixLen = LenW'(5);
  localparam logic [LenW-1:0] CmdLen    = LenW'(3);

  typedef enum logic [4:0] {
    PH_PREFIX    = 5'b00001,
    PH_COMMAND   = 5'b00010,
    PH_PARAMETER = 5'b00100,
    PH_VALUE     = 5'b01000,
    PH_CHECKSUM  = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    CMD_SUB     = 3'd0,
    CMD_RES     = 3'd1,
    CMD_REQ     = 3'd2,
    CMD_SET     = 3'd3,
    CMD_CMD     = 3'd4,
    CMD_UNKNOWN = 3'd5
  } cmd_e;

  typedef struct packed {
    logic       header_valid;
    logic       checksum_match;
    logic [2:0] command_code;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } result_t;

  // expected sentence opener, one char per position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h42;
      3'd2:    ch = 8'h41;
      3'd3:    ch = 8'h50;
      default: ch = ChComma;
    endcase
    return ch;
  endfunction

  function automatic cmd_e classify(input logic [LenW-1:0] len, input logic [23:0] chars);
    cmd_e code;
    code = CMD_UNKNOWN;
    if (len == CmdLen) begin
      case (chars)
        24'h535542: code = CMD_SUB;
        24'h524553: code = CMD_RES;
        24'h524551: code = CMD_REQ;
        24'h534554: code = CMD_SET;
        24'h434D44: code = CMD_CMD;
        default:    code = CMD_UNKNOWN;
      endcase
    end
    return code;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // only meaningful when is_hex holds
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/shchk_core.sv
`default_nettype none

module shchk_core #(
  parameter int unsigned MAX_COMMAND_LEN   = 15,
  parameter int unsigned MAX_PARAMETER_LEN = 31,
  parameter int unsigned MAX_VALUE_LEN     = 63
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        char_i,
  input  wire logic              last_i,
  output shchk_pkg::result_t     res_o
);
  import shchk_pkg::*;

  localparam logic [LenW-1:0] MaxCmd = LenW'(MAX_COMMAND_LEN);
  localparam logic [LenW-1:0] MaxPar = LenW'(MAX_PARAMETER_LEN);
  localparam logic [LenW-1:0] MaxVal = LenW'(MAX_VALUE_LEN);

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      xor_q, xor_d;
  logic [23:0]     cmd_q, cmd_d;
  logic [7:0]      recv_q, recv_d;
  logic [1:0]      hcnt_q, hcnt_d;
  logic            star_q, star_d;
  logic            herr_q, herr_d;
  logic            started_q, started_d;
  cmd_e            class_q, class_d;
  logic            neg_q, neg_d;
  logic            hend_q, hend_d;
  logic            closed_q, closed_d;
  logic [7:0]      recv_eff;
  logic            hdr_ok;

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    xor_d     = xor_q;
    cmd_d     = cmd_q;
    recv_d    = recv_q;
    hcnt_d    = hcnt_q;
    star_d    = star_q;
    herr_d    = herr_q;
    class_d   = class_q;
    neg_d     = neg_q;
    hend_d    = hend_q;
    closed_d  = closed_q;
    started_d = 1'b1;

    // body xor and checksum token
    if (!star_q) begin
      if (char_i == ChStar) begin
        star_d = 1'b1;
      end else if (started_q) begin
        xor_d = xor_q ^ char_i;
      end
    end else if (!closed_q) begin
      if (is_space(char_i)) begin
        if (hcnt_q != 2'd0) closed_d = 1'b1;
      end else begin
        if (!hend_q) begin
          if (hcnt_q == 2'd0 && (char_i == ChPlus || char_i == ChMinus)) begin
            neg_d = (char_i == ChMinus);
          end else if (is_hex(char_i)) begin
            recv_d = {recv_q[3:0], hex_val(char_i)};
          end else begin
            hend_d = 1'b1;
          end
        end
        hcnt_d = hcnt_q + 2'd1;
        if (hcnt_q != 2'd0) closed_d = 1'b1;
      end
    end

    // header form
    if (!herr_q) begin
      case (phase_q)
        PH_PREFIX: begin
          if (len_q >= PrefixLen || char_i != prefix_char(len_q[2:0])) begin
            herr_d = 1'b1;
          end else if (len_q == PrefixLen - LenW'(1)) begin
            phase_d = PH_COMMAND;
            len_d   = '0;
          end else begin
            len_d = len_q + LenW'(1);
          end
        end
        PH_COMMAND: begin
          if (char_i == ChComma) begin
            if (len_q == '0) begin
              herr_d = 1'b1;
            end else begin
              class_d = classify(len_q, cmd_q);
              phase_d = PH_PARAMETER;
              len_d   = '0;
            end
          end else if (char_i == ChStar || len_q >= MaxCmd) begin
            herr_d = 1'b1;
          end else begin
            if (len_q < CmdLen) cmd_d = {cmd_q[15:0], char_i};
            len_d = len_q + LenW'(1);
          end
        end
        PH_PARAMETER: begin
          if (char_i == ChComma) begin
            if (len_q == '0) begin
              herr_d = 1'b1;
            end else begin
              phase_d = PH_VALUE;
              len_d   = '0;
            end
          end else if (char_i == ChStar || len_q >= MaxPar) begin
            herr_d = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
          end
        end
        PH_VALUE: begin
          if (char_i == ChStar) begin
            if (len_q == '0) begin
              herr_d = 1'b1;
            end else begin
              phase_d = PH_CHECKSUM;
              len_d   = '0;
            end
          end else if (len_q >= MaxVal) begin
            herr_d = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result view of the state after this byte
  always_comb begin
    recv_eff = '0;
    if (hcnt_d != 2'd0) recv_eff = neg_d ? (~recv_d) + 8'd1 : recv_d;
    hdr_ok = !herr_d && (phase_d == PH_CHECKSUM) && (hcnt_d != 2'd0);
    res_o.header_valid   = hdr_ok;
    res_o.checksum_match = star_d && (hcnt_d != 2'd0) && (xor_d == recv_eff);
    res_o.command_code   = hdr_ok ? class_d : CMD_UNKNOWN;
    res_o.computed_sum   = xor_d;
    res_o.received_sum   = recv_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PREFIX;
      len_q     <= '0;
      xor_q     <= '0;
      cmd_q     <= '0;
      recv_q    <= '0;
      hcnt_q    <= '0;
      star_q    <= 1'b0;
      herr_q    <= 1'b0;
      started_q <= 1'b0;
      class_q   <= CMD_UNKNOWN;
      neg_q     <= 1'b0;
      hend_q    <= 1'b0;
      closed_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q   <= PH_PREFIX;
        len_q     <= '0;
        xor_q     <= '0;
        cmd_q     <= '0;
        recv_q    <= '0;
        hcnt_q    <= '0;
        star_q    <= 1'b0;
        herr_q    <= 1'b0;
        started_q <= 1'b0;
        class_q   <= CMD_UNKNOWN;
        neg_q     <= 1'b0;
        hend_q    <= 1'b0;
        closed_q  <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        len_q     <= len_d;
        xor_q     <= xor_d;
        cmd_q     <= cmd_d;
        recv_q    <= recv_d;
        hcnt_q    <= hcnt_d;
        star_q    <= star_d;
        herr_q    <= herr_d;
        started_q <= started_d;
        class_q   <= class_d;
        neg_q     <= neg_d;
        hend_q    <= hend_d;
        closed_q  <= closed_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/shchk_out_reg.sv
`default_nettype none

module shchk_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire shchk_pkg::result_t res_i,
  input  wire logic          stall_i,
  output logic               free_o,
  output logic               valid_o,
  output shchk_pkg::result_t res_o
);
  import shchk_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o = !vld_q || !stall_i;
  assign vld_d  = load_i || (vld_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sentence_header_checksum_check_unit.sv
// channel  | handshake                | payload
// ---------+--------------------------+-------------------------------------------
// in       | in_valid_i / in_stall_o  | char_in_i[7:0], final_byte_i
// out      | out_valid_o / out_stall_i| header_valid_o, checksum_match_o,
//          |                          | command_code_o[2:0], computed_sum_o[7:0],
//          |                          | received_sum_o[7:0]
//
// one byte per cycle while in_stall_o is low; each byte passes through the input register
// and the sentence result is loaded into the result register as its final byte leaves the input register
// the parse state update is one compare/xor level between input and state regs
// reset clears all handshake and parse state, no clearing pass is needed
// in_stall_o rises only while a final byte waits for a full, stalled result reg
`default_nettype none

module sentence_header_checksum_check_unit #(
  parameter int unsigned MAX_COMMAND_LEN   = shchk_pkg::DefMaxCommandLen,
  parameter int unsigned MAX_PARAMETER_LEN = shchk_pkg::DefMaxParameterLen,
  parameter int unsigned MAX_VALUE_LEN     = shchk_pkg::DefMaxValueLen
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input transactions
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic       final_byte_i,
  // result transactions
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            header_valid_o,
  output logic            checksum_match_o,
  output logic [2:0]      command_code_o,
  output logic [7:0]      computed_sum_o,
  output logic [7:0]      received_sum_o
);
  import shchk_pkg::*;

  `include "sentence_header_checksum_check_unit_macros.svh"

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       in_take;

  // byte leaves the input register into the parse state
  logic       advance;
  logic       out_free;
  logic       out_load;

  result_t    res_next;
  result_t    res_out;

  // a plain byte never waits; a final byte waits for room in the result reg
  assign advance    = in_vld_q && (!in_last_q || out_free);
  assign out_load   = advance && in_last_q;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= char_in_i;
      in_last_q <= final_byte_i;
    end
  end

  // header parser, body xor and checksum token reader
  shchk_core #(
    .MAX_COMMAND_LEN  (MAX_COMMAND_LEN),
    .MAX_PARAMETER_LEN(MAX_PARAMETER_LEN),
    .MAX_VALUE_LEN    (MAX_VALUE_LEN)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .char_i(in_char_q),
    .last_i(in_last_q),
    .res_o (res_next)
  );

  // result register, keeps the input side moving while a result waits
  shchk_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .res_i  (res_next),
    .stall_i(out_stall_i),
    .free_o (out_free),
    .valid_o(out_valid_o),
    .res_o  (res_out)
  );

  assign header_valid_o   = res_out.header_valid;
  assign checksum_match_o = res_out.checksum_match;
  assign command_code_o   = res_out.command_code;
  assign computed_sum_o   = res_out.computed_sum;
  assign received_sum_o   = res_out.received_sum;

  // an invalid header always reports the unknown command
  `SHCHK_ASSERT(a_bad_hdr_unknown, clk_i, rst_ni,
    !(out_valid_o && !header_valid_o) || (command_code_o == CMD_UNKNOWN))
  // a match means both sums agree
  `SHCHK_ASSERT(a_match_sums, clk_i, rst_ni,
    !(out_valid_o && checksum_match_o) || (computed_sum_o == received_sum_o))
  // only a held final byte can stall the input
  `SHCHK_ASSERT(a_stall_final, clk_i, rst_ni,
    !in_stall_o || (in_vld_q && in_last_q && out_valid_o && out_stall_i))
  // a finished sentence shows up in the result register next cycle
  `SHCHK_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, out_load, out_valid_o)

endmodule

`default_nettype wire
